@@ rtl/mi3_pkg.sv @@
// Shared constants for the 3x3 matrix inverse block.
// Holds parameter defaults, the cofactor index table and the latency figure.
package mi3_pkg;

   localparam int unsigned ELEM_WIDTH_DEF = 16;
   localparam int unsigned FRAC_BITS_DEF  = 8;
   localparam int unsigned NUM_ELEMS      = 9;

   // adj[i] = a[c0]*a[c3] - a[c1]*a[c2], row-major entry numbers
   localparam int unsigned COF_IDX [NUM_ELEMS][4] = '{
      '{4, 5, 7, 8}, '{2, 1, 8, 7}, '{1, 2, 4, 5},
      '{5, 3, 8, 6}, '{0, 2, 6, 8}, '{2, 0, 5, 3},
      '{3, 4, 6, 7}, '{1, 0, 7, 6}, '{0, 1, 3, 4}
   };

   function automatic int unsigned latency(input int unsigned elem_width);
      return elem_width + 9;
   endfunction

endpackage

@@ rtl/matrix_inverse_3x3.sv @@
// Top level of the 3x3 matrix inverse block (adjugate over determinant).
// Depends on mi3_pkg, mi3_front and mi3_lane.
//
// A request carries nine signed fixed-point entries req_a11..req_a33 and is
// taken at a rising edge with start high and busy low. busy is always low:
// a new request is taken every cycle, any number back to back.
// The result r11..r33 and singular appears on the rsp_ ports for one cycle,
// marked by rsp_strobe, after the pipeline: five stages form cofactors and
// determinant, then nine lanes in parallel run a restoring divider of one
// quotient bit a stage (ELEM_WIDTH + 1 stages) plus preparation and
// rounding, then a merge register gathers the lanes.
// One result leaves per cycle.
// A zero determinant gives singular high and all entries zero.
// Reset, synchronous and active high, drops every request in flight.
// The receiver cannot stall; results are never held.
module matrix_inverse_3x3 #(
   parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [ELEM_WIDTH-1:0] req_a11,
   input  logic signed [ELEM_WIDTH-1:0] req_a12,
   input  logic signed [ELEM_WIDTH-1:0] req_a13,
   input  logic signed [ELEM_WIDTH-1:0] req_a21,
   input  logic signed [ELEM_WIDTH-1:0] req_a22,
   input  logic signed [ELEM_WIDTH-1:0] req_a23,
   input  logic signed [ELEM_WIDTH-1:0] req_a31,
   input  logic signed [ELEM_WIDTH-1:0] req_a32,
   input  logic signed [ELEM_WIDTH-1:0] req_a33,
   output logic                         rsp_strobe,
   output logic signed [ELEM_WIDTH-1:0] rsp_r11,
   output logic signed [ELEM_WIDTH-1:0] rsp_r12,
   output logic signed [ELEM_WIDTH-1:0] rsp_r13,
   output logic signed [ELEM_WIDTH-1:0] rsp_r21,
   output logic signed [ELEM_WIDTH-1:0] rsp_r22,
   output logic signed [ELEM_WIDTH-1:0] rsp_r23,
   output logic signed [ELEM_WIDTH-1:0] rsp_r31,
   output logic signed [ELEM_WIDTH-1:0] rsp_r32,
   output logic signed [ELEM_WIDTH-1:0] rsp_r33,
   output logic                         rsp_singular
);
   import mi3_pkg::*;

   localparam int unsigned W = ELEM_WIDTH;

   logic signed [W-1:0]     a_in [NUM_ELEMS];
   logic                    f_valid;
   logic signed [2*W:0]     f_cof [NUM_ELEMS];
   logic signed [3*W+2:0]   f_det;
   logic [NUM_ELEMS-1:0]    l_valid;
   logic [W-1:0]            l_r [NUM_ELEMS];
   logic [NUM_ELEMS-1:0]    l_sing;

   logic                    strobe_ff;
   logic [W-1:0]            r_ff [NUM_ELEMS];
   logic                    sing_ff;

   assign a_in = '{req_a11, req_a12, req_a13, req_a21, req_a22,
                   req_a23, req_a31, req_a32, req_a33};
   assign busy = 1'b0;

   mi3_front #(.ELEM_WIDTH(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_a      (a_in),
      .out_valid (f_valid),
      .out_cof   (f_cof),
      .out_det   (f_det)
   );

   for (genvar i = 0; i < NUM_ELEMS; i++) begin : g_lane
      mi3_lane #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (f_valid),
         .in_cof       (f_cof[i]),
         .in_det       (f_det),
         .out_valid    (l_valid[i]),
         .out_r        (l_r[i]),
         .out_singular (l_sing[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= &l_valid;
      end
      r_ff    <= l_r;
      sing_ff <= |l_sing;
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_r11      = r_ff[0];
   assign rsp_r12      = r_ff[1];
   assign rsp_r13      = r_ff[2];
   assign rsp_r21      = r_ff[3];
   assign rsp_r22      = r_ff[4];
   assign rsp_r23      = r_ff[5];
   assign rsp_r31      = r_ff[6];
   assign rsp_r32      = r_ff[7];
   assign rsp_r33      = r_ff[8];
   assign rsp_singular = sing_ff;

endmodule

@@ rtl/mi3_front.sv @@
// Cofactor and determinant pipeline of the 3x3 matrix inverse block.
// Depends on mi3_pkg; five register stages from request to determinant.
module mi3_front #(
   parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [ELEM_WIDTH-1:0]      in_a [mi3_pkg::NUM_ELEMS],
   output logic                              out_valid,
   output logic signed [2*ELEM_WIDTH:0]      out_cof [mi3_pkg::NUM_ELEMS],
   output logic signed [3*ELEM_WIDTH+2:0]    out_det
);
   import mi3_pkg::*;

   localparam int unsigned W  = ELEM_WIDTH;
   localparam int unsigned PW = 2 * W;
   localparam int unsigned CW = 2 * W + 1;
   localparam int unsigned TW = 3 * W + 1;
   localparam int unsigned DW = 3 * W + 3;

   logic [4:0]              valid_ff;
   logic signed [W-1:0]     a_ff [NUM_ELEMS];
   logic signed [PW-1:0]    p_ff [NUM_ELEMS][2];
   logic signed [W-1:0]     arow_b_ff [3];
   logic signed [W-1:0]     arow_c_ff [3];
   logic signed [CW-1:0]    cof_c_ff [NUM_ELEMS];
   logic signed [CW-1:0]    cof_d_ff [NUM_ELEMS];
   logic signed [CW-1:0]    cof_e_ff [NUM_ELEMS];
   logic signed [TW-1:0]    t_ff [3];
   logic signed [DW-1:0]    det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= in_a;
      for (int i = 0; i < 3; i++) begin
         arow_b_ff[i] <= a_ff[i];
         arow_c_ff[i] <= arow_b_ff[i];
      end
      for (int i = 0; i < NUM_ELEMS; i++) begin
         p_ff[i][0] <= a_ff[COF_IDX[i][0]] * a_ff[COF_IDX[i][3]];
         p_ff[i][1] <= a_ff[COF_IDX[i][1]] * a_ff[COF_IDX[i][2]];
         cof_c_ff[i] <= CW'(p_ff[i][0]) - CW'(p_ff[i][1]);
         cof_d_ff[i] <= cof_c_ff[i];
         cof_e_ff[i] <= cof_d_ff[i];
      end
      t_ff[0] <= TW'(cof_c_ff[0]) * TW'(arow_c_ff[0]);
      t_ff[1] <= TW'(cof_c_ff[3]) * TW'(arow_c_ff[1]);
      t_ff[2] <= TW'(cof_c_ff[6]) * TW'(arow_c_ff[2]);
      det_ff  <= DW'(t_ff[0]) + DW'(t_ff[1]) + DW'(t_ff[2]);
   end

   assign out_valid = valid_ff[4];
   assign out_cof   = cof_e_ff;
   assign out_det   = det_ff;

endmodule

@@ rtl/mi3_lane.sv @@
// One division lane: round(cof * 2^(2F) / det), saturated, one quotient bit a stage.
// Depends on mi3_pkg; ELEM_WIDTH + 3 register stages.
module mi3_lane #(
   parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic signed [2*ELEM_WIDTH:0]    in_cof,
   input  logic signed [3*ELEM_WIDTH+2:0]  in_det,
   output logic                            out_valid,
   output logic [ELEM_WIDTH-1:0]           out_r,
   output logic                            out_singular
);
   import mi3_pkg::*;

   localparam int unsigned W  = ELEM_WIDTH;
   localparam int unsigned CW = 2 * W + 1;
   localparam int unsigned DW = 3 * W + 3;
   localparam int unsigned XW = DW + W + 2 * FRAC_BITS + 2;
   localparam int unsigned NS = W + 1;
   localparam int unsigned QW = W + 2;

   logic signed [XW-1:0] cof_x;
   logic signed [XW-1:0] det_x;
   logic [XW-1:0]        cmag;
   logic [XW-1:0]        dmag;
   logic [XW-1:0]        rem0;

   logic [XW-1:0]  rem_ff [0:NS];
   logic [XW-1:0]  d_ff   [0:NS];
   logic [W:0]     q_ff   [0:NS];
   logic [NS:0]    valid_ff;
   logic [NS:0]    neg_ff;
   logic [NS:0]    sat_ff;
   logic [NS:0]    cz_ff;
   logic [NS:0]    dz_ff;

   logic            ovalid_ff;
   logic [W-1:0]    r_ff;
   logic            sing_ff;

   assign cof_x = XW'(in_cof);
   assign det_x = XW'(in_det);
   assign cmag  = in_cof[CW-1] ? XW'(-cof_x) : XW'(cof_x);
   assign dmag  = in_det[DW-1] ? XW'(-det_x) : XW'(det_x);
   assign rem0  = cmag << (2 * FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0] <= rem0;
      d_ff[0]   <= dmag;
      q_ff[0]   <= '0;
      neg_ff[0] <= in_cof[CW-1] ^ in_det[DW-1];
      sat_ff[0] <= (rem0 >> (W + 1)) >= dmag;
      cz_ff[0]  <= (in_cof == '0);
      dz_ff[0]  <= (in_det == '0);
   end

   for (genvar j = 0; j < NS; j++) begin : g_step
      localparam int unsigned K = W - j;
      logic [XW-1:0] dsh;
      logic          take;
      assign dsh  = d_ff[j] << K;
      assign take = rem_ff[j] >= dsh;
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else begin
            valid_ff[j+1] <= valid_ff[j];
         end
         rem_ff[j+1] <= take ? rem_ff[j] - dsh : rem_ff[j];
         q_ff[j+1]   <= q_ff[j] | ((W+1)'(take) << K);
         d_ff[j+1]   <= d_ff[j];
         neg_ff[j+1] <= neg_ff[j];
         sat_ff[j+1] <= sat_ff[j];
         cz_ff[j+1]  <= cz_ff[j];
         dz_ff[j+1]  <= dz_ff[j];
      end
   end

   logic [QW-1:0] qr;
   logic [QW-1:0] limit;
   logic [QW-1:0] qs;
   logic [W-1:0]  rval;

   always_comb begin
      qr    = QW'(q_ff[NS]) + QW'((rem_ff[NS] << 1) >= d_ff[NS]);
      limit = neg_ff[NS] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
      qs    = (sat_ff[NS] || qr > limit) ? limit : qr;
      if (cz_ff[NS] || dz_ff[NS]) begin
         rval = '0;
      end else if (neg_ff[NS]) begin
         rval = W'(-qs);
      end else begin
         rval = qs[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= valid_ff[NS];
      end
      r_ff    <= rval;
      sing_ff <= dz_ff[NS];
   end

   assign out_valid    = ovalid_ff;
   assign out_r        = r_ff;
   assign out_singular = sing_ff;

endmodule

@@ rtl/mi3_checker.sv @@
// Port-level checks for the 3x3 matrix inverse block, bound to the top level.
// Depends on mi3_pkg for the latency figure.
module mi3_checker #(
   parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input logic [ELEM_WIDTH-1:0] rsp_r11,
   input logic [ELEM_WIDTH-1:0] rsp_r22,
   input logic [ELEM_WIDTH-1:0] rsp_r33,
   input logic                  rsp_singular
);
   import mi3_pkg::*;

   localparam int unsigned LAT = latency(ELEM_WIDTH);

   a_no_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_fwd : assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_strobe)
      else $error("request produced no response");

   a_back : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("response without request");

   a_sing : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_singular) |-> (rsp_r11 == '0 && rsp_r22 == '0 && rsp_r33 == '0))
      else $error("singular response with nonzero entries");

endmodule

bind matrix_inverse_3x3 mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_r11      (rsp_r11),
   .rsp_r22      (rsp_r22),
   .rsp_r33      (rsp_r33),
   .rsp_singular (rsp_singular)
);
